>>> rtl/mdns_query_matcher_unit_assert.svh
// Assertion macros shared by the query matcher RTL.
// No dependencies; included by modules that carry checks.
`ifndef MDNS_QUERY_MATCHER_UNIT_ASSERT_SVH
`define MDNS_QUERY_MATCHER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MQM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MQM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mqm_pkg.sv
// Types and constants for the mDNS query matcher.
// No dependencies.
package mqm_pkg;

    localparam logic [1:0] FUNC_PACKET = 2'd0;
    localparam logic [1:0] FUNC_NAME   = 2'd1;
    localparam logic [1:0] FUNC_ENTRY  = 2'd2;

    localparam logic [1:0] TC_TYPE_HI  = 2'd0;
    localparam logic [1:0] TC_TYPE_LO  = 2'd1;
    localparam logic [1:0] TC_CLASS_HI = 2'd2;
    localparam logic [1:0] TC_CLASS_LO = 2'd3;

    localparam int          HDR_BYTES  = 12;
    localparam logic [7:0]  FLAG_MASK  = 8'hf8;
    localparam logic [7:0]  PTR_MASK   = 8'hc0;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [15:0] TYPE_ANY   = 16'd255;
    localparam logic [15:0] CLASS_IN   = 16'd1;
    localparam logic [15:0] CLASS_ANY  = 16'd255;
    localparam logic [15:0] CLASS_MASK = 16'h7fff;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        end_of_packet;
        logic [3:0]  entry;
        logic [7:0]  name_pos;
        logic [7:0]  name_len;
        logic [31:0] host_addr;
    } req_t;

    typedef struct packed {
        logic [15:0] query_id;
        logic [4:0]  answer_index;
        logic [5:0]  answer_count;
        logic [3:0]  record_entry;
        logic [31:0] record_addr;
        logic        last_answer;
    } ans_t;

    typedef struct packed {
        logic       accept;
        logic       hdr_step;
        logic       hdr_fin;
        logic       q_begin;
        logic       len_label;
        logic       len_ptr;
        logic       len_end;
        logic       ptr_follow;
        logic       lab_byte;
        logic       tc_byte;
        logic [1:0] tc_sel;
        logic       q_inc;
        logic       ent_first;
        logic       ent_inc;
        logic       cmp_begin;
        logic       cmp_byte;
        logic       found;
        logic       emit_begin;
        logic       emit;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic pkt_end;
        logic short_pkt;
        logic hdr_last;
        logic hdr_ok;
        logic q_done;
        logic none_matched;
        logic byte_ok;
        logic dom_full;
        logic is_ptr;
        logic is_zero;
        logic depth_ok;
        logic lab_last;
        logic tc_ok;
        logic ent_end;
        logic ent_cand;
        logic cmp_eq;
        logic cmp_last;
        logic ml_full;
        logic emit_last;
    } status_t;

endpackage

>>> rtl/mdns_query_matcher_unit.sv
// mDNS A-record query matcher, top level.
// Depends on mqm_pkg, mqm_ctrl, mqm_datapath and mqm_ram.
//
// Usage: a word on request is taken at a clock edge where start is high and
// busy is low. func 1 writes one byte of a host-table name, func 2 writes an
// entry's encoded name length and IPv4 address. func 0 appends one query byte
// per word. On the word that carries end_of_packet the stored packet is
// parsed and busy stays high until the answers are out. Parsing walks the
// stored bytes one per cycle, then each question's name is compared against
// the table one byte per cycle per candidate entry (entries whose length
// differs are skipped without a compare), so the parse time grows with
// packet size, question count and table hits.
// Answers come one per cycle on answer, each marked by answer_valid for one
// cycle, in the cycle after the sequencer emits it; the last may show in the
// first cycle after busy falls. The receiver cannot stall the block.
// Dropped packets give no answers. Reset clears the packet length, all table
// lengths (entries unused) and the sequencer.
module mdns_query_matcher_unit #(
    parameter int MSG_BYTES         = 2048,
    parameter int NUM_RECORDS       = 16,
    parameter int NAME_BYTES        = 256,
    parameter int DOMAIN_BYTES      = 512,
    parameter int MAX_ANSWERS       = 32,
    parameter int MAX_POINTER_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mqm_pkg::req_t request,
    output logic          busy,
    output logic          answer_valid,
    output mqm_pkg::ans_t answer
);
    mqm_pkg::cmd_t    cmd;
    mqm_pkg::status_t status;

    mqm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mqm_datapath #(
        .MSG_BYTES         (MSG_BYTES),
        .NUM_RECORDS       (NUM_RECORDS),
        .NAME_BYTES        (NAME_BYTES),
        .DOMAIN_BYTES      (DOMAIN_BYTES),
        .MAX_ANSWERS       (MAX_ANSWERS),
        .MAX_POINTER_DEPTH (MAX_POINTER_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .status       (status),
        .answer_valid (answer_valid),
        .answer       (answer)
    );
endmodule

>>> rtl/mqm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/mqm_ctrl.sv
// Parse sequencer for the mDNS query matcher.
// Depends on mqm_pkg and mdns_query_matcher_unit_assert.svh.
`include "mdns_query_matcher_unit_assert.svh"

module mqm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  mqm_pkg::status_t status,
    output mqm_pkg::cmd_t   cmd,
    output logic            busy
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HDR0   = 5'd1;
    localparam logic [4:0] S_HDR    = 5'd2;
    localparam logic [4:0] S_HDRCHK = 5'd3;
    localparam logic [4:0] S_QSTART = 5'd4;
    localparam logic [4:0] S_LEN    = 5'd5;
    localparam logic [4:0] S_PTR    = 5'd6;
    localparam logic [4:0] S_LAB    = 5'd7;
    localparam logic [4:0] S_T0     = 5'd8;
    localparam logic [4:0] S_T1     = 5'd9;
    localparam logic [4:0] S_C0     = 5'd10;
    localparam logic [4:0] S_C1     = 5'd11;
    localparam logic [4:0] S_QCHK   = 5'd12;
    localparam logic [4:0] S_ENT    = 5'd13;
    localparam logic [4:0] S_CMP    = 5'd14;
    localparam logic [4:0] S_FOUND  = 5'd15;
    localparam logic [4:0] S_EMIT   = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (status.pkt_end)
                    begin
                        state_next = S_HDR0;
                    end
                end
            end
            S_HDR0:
            begin
                if (status.short_pkt)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                cmd.hdr_step = 1'b1;
                if (status.hdr_last)
                begin
                    state_next = S_HDRCHK;
                end
            end
            S_HDRCHK:
            begin
                if (status.hdr_ok)
                begin
                    cmd.hdr_fin = 1'b1;
                    state_next  = S_QSTART;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QSTART:
            begin
                if (!status.q_done)
                begin
                    cmd.q_begin = 1'b1;
                    state_next  = S_LEN;
                end
                else if (status.none_matched)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit_begin = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_LEN:
            begin
                if (!status.byte_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.is_ptr)
                begin
                    cmd.len_ptr = 1'b1;
                    state_next  = S_PTR;
                end
                else if (status.dom_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else if (status.is_zero)
                begin
                    cmd.len_end = 1'b1;
                    state_next  = S_T0;
                end
                else
                begin
                    cmd.len_label = 1'b1;
                    state_next    = S_LAB;
                end
            end
            S_PTR:
            begin
                if (!status.byte_ok || !status.depth_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.ptr_follow = 1'b1;
                    state_next     = S_LEN;
                end
            end
            S_LAB:
            begin
                if (!status.byte_ok || status.dom_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.lab_byte = 1'b1;
                    if (status.lab_last)
                    begin
                        state_next = S_LEN;
                    end
                end
            end
            S_T0, S_T1, S_C0, S_C1:
            begin
                if (!status.byte_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.tc_byte = 1'b1;
                    unique case (state_reg)
                        S_T0:
                        begin
                            cmd.tc_sel = mqm_pkg::TC_TYPE_HI;
                            state_next = S_T1;
                        end
                        S_T1:
                        begin
                            cmd.tc_sel = mqm_pkg::TC_TYPE_LO;
                            state_next = S_C0;
                        end
                        S_C0:
                        begin
                            cmd.tc_sel = mqm_pkg::TC_CLASS_HI;
                            state_next = S_C1;
                        end
                        default:
                        begin
                            cmd.tc_sel = mqm_pkg::TC_CLASS_LO;
                            state_next = S_QCHK;
                        end
                    endcase
                end
            end
            S_QCHK:
            begin
                if (status.tc_ok)
                begin
                    cmd.ent_first = 1'b1;
                    state_next    = S_ENT;
                end
                else
                begin
                    cmd.q_inc  = 1'b1;
                    state_next = S_QSTART;
                end
            end
            S_ENT:
            begin
                if (status.ent_end)
                begin
                    cmd.q_inc  = 1'b1;
                    state_next = S_QSTART;
                end
                else if (status.ent_cand)
                begin
                    cmd.cmp_begin = 1'b1;
                    state_next    = S_CMP;
                end
                else
                begin
                    cmd.ent_inc = 1'b1;
                end
            end
            S_CMP:
            begin
                if (!status.cmp_eq)
                begin
                    cmd.ent_inc = 1'b1;
                    state_next  = S_ENT;
                end
                else if (status.cmp_last)
                begin
                    state_next = S_FOUND;
                end
                else
                begin
                    cmd.cmp_byte = 1'b1;
                end
            end
            S_FOUND:
            begin
                if (status.ml_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.found  = 1'b1;
                    state_next = S_QSTART;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MQM_ASSERT_NOW(a_lab_safe, cmd.lab_byte, status.byte_ok && !status.dom_full, "label byte taken past bounds")
    `MQM_ASSERT_NOW(a_found_room, cmd.found, !status.ml_full, "match list overrun")
    `MQM_ASSERT_NEXT(a_emit_end, cmd.emit && status.emit_last, state_reg == S_IDLE, "emit did not end")
    `MQM_ASSERT_NOW(a_cmp_safe, state_reg == S_CMP, !status.ent_end, "compare on missing entry")
endmodule

>>> rtl/mqm_datapath.sv
// Datapath of the mDNS query matcher: stores, pointers, counters, compare.
// Depends on mqm_pkg and mqm_ram.
module mqm_datapath #(
    parameter int MSG_BYTES         = 2048,
    parameter int NUM_RECORDS       = 16,
    parameter int NAME_BYTES        = 256,
    parameter int DOMAIN_BYTES      = 512,
    parameter int MAX_ANSWERS       = 32,
    parameter int MAX_POINTER_DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mqm_pkg::req_t    request,
    input  mqm_pkg::cmd_t    cmd,
    output mqm_pkg::status_t status,
    output logic             answer_valid,
    output mqm_pkg::ans_t    answer
);
    localparam int PAW = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
    localparam int PLW = $clog2(MSG_BYTES + 1);
    localparam int RW  = (PLW > 14) ? PLW : 14;
    localparam int EW  = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;
    localparam int ECW = $clog2(NUM_RECORDS + 1);
    localparam int NTD = NUM_RECORDS * NAME_BYTES;
    localparam int NTW = $clog2(NTD);
    localparam int DAW = $clog2(DOMAIN_BYTES);
    localparam int DUW = $clog2(DOMAIN_BYTES + 1);
    localparam int MLW = (MAX_ANSWERS > 1) ? $clog2(MAX_ANSWERS) : 1;
    localparam int MCW = $clog2(MAX_ANSWERS + 1);
    localparam int DPW = $clog2(MAX_POINTER_DEPTH + 1);

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    logic [PLW-1:0] plen_reg, plen_next;
    logic [RW-1:0]  rd_pos_reg, rd_pos_next;
    logic [RW-1:0]  resume_reg, resume_next;
    logic           jumped_reg, jumped_next;
    logic [DPW-1:0] depth_reg, depth_next;
    logic [5:0]     ptr_hi_reg, ptr_hi_next;
    logic [15:0]    id_reg, id_next;
    logic [7:0]     flags_reg, flags_next;
    logic [15:0]    qd_reg, qd_next;
    logic [15:0]    q_reg, q_next;
    logic [DUW-1:0] dom_used_reg, dom_used_next;
    logic [7:0]     left_reg, left_next;
    logic [15:0]    type_reg, type_next;
    logic [15:0]    cls_reg, cls_next;
    logic [ECW-1:0] e_reg, e_next;
    logic [7:0]     i_reg, i_next;
    logic [7:0]     cleft_reg, cleft_next;
    logic [MCW-1:0] mc_reg, mc_next;
    logic [MCW-1:0] k_reg, k_next;
    logic           ans_valid_reg, ans_valid_next;
    mqm_pkg::ans_t  ans_reg, ans_next;
    logic [7:0]     name_len_reg [NUM_RECORDS];
    logic [31:0]    addr_reg [NUM_RECORDS];

    logic [7:0]     pq, nq, dq;
    logic [EW-1:0]  mlq;
    logic [RW-1:0]  rd_plus;
    logic [7:0]     nlen;
    logic [15:0]    cls_m;
    logic           entry_ok, pkt_we, name_we, dom_we;

    assign rd_plus  = rd_pos_reg + RW'(1);
    assign entry_ok = 9'(request.entry) < 9'(NUM_RECORDS);
    assign pkt_we   = cmd.accept && request.func == mqm_pkg::FUNC_PACKET
                      && plen_reg < PLW'(MSG_BYTES);
    assign name_we  = cmd.accept && request.func == mqm_pkg::FUNC_NAME && entry_ok
                      && 9'(request.name_pos) < 9'(NAME_BYTES);
    assign dom_we   = cmd.len_label || cmd.len_end || cmd.lab_byte;
    assign nlen     = name_len_reg[e_reg[EW-1:0]];
    assign cls_m    = cls_reg & mqm_pkg::CLASS_MASK;

    always_comb
    begin
        plen_next      = plen_reg;
        rd_pos_next    = rd_pos_reg;
        resume_next    = resume_reg;
        jumped_next    = jumped_reg;
        depth_next     = depth_reg;
        ptr_hi_next    = ptr_hi_reg;
        id_next        = id_reg;
        flags_next     = flags_reg;
        qd_next        = qd_reg;
        q_next         = q_reg;
        dom_used_next  = dom_used_reg;
        left_next      = left_reg;
        type_next      = type_reg;
        cls_next       = cls_reg;
        e_next         = e_reg;
        i_next         = i_reg;
        cleft_next     = cleft_reg;
        mc_next        = mc_reg;
        k_next         = k_reg;
        ans_valid_next = 1'b0;
        ans_next       = ans_reg;

        if (pkt_we)
        begin
            plen_next = plen_reg + PLW'(1);
        end
        if (cmd.accept && request.func == mqm_pkg::FUNC_PACKET && request.end_of_packet)
        begin
            rd_pos_next = '0;
        end
        if (cmd.hdr_step)
        begin
            rd_pos_next = rd_plus;
            if (rd_pos_reg < RW'(2))
            begin
                id_next = {id_reg[7:0], pq};
            end
            if (rd_pos_reg == RW'(2))
            begin
                flags_next = pq;
            end
            if (rd_pos_reg == RW'(4) || rd_pos_reg == RW'(5))
            begin
                qd_next = {qd_reg[7:0], pq};
            end
        end
        if (cmd.hdr_fin)
        begin
            q_next  = '0;
            mc_next = '0;
        end
        if (cmd.q_begin)
        begin
            dom_used_next = '0;
            depth_next    = '0;
            jumped_next   = 1'b0;
        end
        if (cmd.len_label)
        begin
            left_next     = pq;
            rd_pos_next   = rd_plus;
            dom_used_next = dom_used_reg + DUW'(1);
        end
        if (cmd.len_ptr)
        begin
            ptr_hi_next = pq[5:0];
            rd_pos_next = rd_plus;
        end
        if (cmd.len_end)
        begin
            dom_used_next = dom_used_reg + DUW'(1);
            rd_pos_next   = jumped_reg ? resume_reg : rd_plus;
        end
        if (cmd.ptr_follow)
        begin
            rd_pos_next = RW'({ptr_hi_reg, pq});
            depth_next  = depth_reg + DPW'(1);
            if (!jumped_reg)
            begin
                jumped_next = 1'b1;
                resume_next = rd_plus;
            end
        end
        if (cmd.lab_byte)
        begin
            left_next     = left_reg - 8'd1;
            dom_used_next = dom_used_reg + DUW'(1);
            rd_pos_next   = rd_plus;
        end
        if (cmd.tc_byte)
        begin
            rd_pos_next = rd_plus;
            unique case (cmd.tc_sel)
                mqm_pkg::TC_TYPE_HI, mqm_pkg::TC_TYPE_LO: type_next = {type_reg[7:0], pq};
                default:                                  cls_next  = {cls_reg[7:0], pq};
            endcase
        end
        if (cmd.q_inc || cmd.found)
        begin
            q_next = q_reg + 16'd1;
        end
        if (cmd.ent_first)
        begin
            e_next = '0;
        end
        if (cmd.ent_inc)
        begin
            e_next = e_reg + ECW'(1);
        end
        if (cmd.cmp_begin)
        begin
            i_next     = '0;
            cleft_next = '0;
        end
        if (cmd.cmp_byte)
        begin
            i_next     = i_reg + 8'd1;
            cleft_next = (cleft_reg != 8'd0) ? cleft_reg - 8'd1 : nq;
        end
        if (cmd.found)
        begin
            mc_next = mc_reg + MCW'(1);
        end
        if (cmd.emit_begin)
        begin
            k_next = '0;
        end
        if (cmd.emit)
        begin
            k_next                = k_reg + MCW'(1);
            ans_valid_next        = 1'b1;
            ans_next.query_id     = id_reg;
            ans_next.answer_index = 5'(k_reg);
            ans_next.answer_count = 6'(mc_reg);
            ans_next.record_entry = 4'(mlq);
            ans_next.record_addr  = addr_reg[mlq];
            ans_next.last_answer  = status.emit_last;
        end
        if (cmd.finish)
        begin
            plen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg      <= '0;
            rd_pos_reg    <= '0;
            resume_reg    <= '0;
            jumped_reg    <= 1'b0;
            depth_reg     <= '0;
            q_reg         <= '0;
            dom_used_reg  <= '0;
            left_reg      <= '0;
            e_reg         <= '0;
            i_reg         <= '0;
            cleft_reg     <= '0;
            mc_reg        <= '0;
            k_reg         <= '0;
            ans_valid_reg <= 1'b0;
            for (int n = 0; n < NUM_RECORDS; n++)
            begin
                name_len_reg[n] <= '0;
            end
        end
        else
        begin
            plen_reg      <= plen_next;
            rd_pos_reg    <= rd_pos_next;
            resume_reg    <= resume_next;
            jumped_reg    <= jumped_next;
            depth_reg     <= depth_next;
            q_reg         <= q_next;
            dom_used_reg  <= dom_used_next;
            left_reg      <= left_next;
            e_reg         <= e_next;
            i_reg         <= i_next;
            cleft_reg     <= cleft_next;
            mc_reg        <= mc_next;
            k_reg         <= k_next;
            ans_valid_reg <= ans_valid_next;
            if (cmd.accept && request.func == mqm_pkg::FUNC_ENTRY && entry_ok)
            begin
                name_len_reg[EW'(request.entry)] <= request.name_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_hi_reg <= ptr_hi_next;
        id_reg     <= id_next;
        flags_reg  <= flags_next;
        qd_reg     <= qd_next;
        type_reg   <= type_next;
        cls_reg    <= cls_next;
        ans_reg    <= ans_next;
        if (cmd.accept && request.func == mqm_pkg::FUNC_ENTRY && entry_ok)
        begin
            addr_reg[EW'(request.entry)] <= request.host_addr;
        end
    end

    // packet read address tracks rd_pos_next, so pq is always the byte at rd_pos (low PAW bits)
    mqm_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_pkt (
        .clk   (clk),
        .we    (pkt_we),
        .waddr (plen_reg[PAW-1:0]),
        .wdata (request.data_byte),
        .raddr (rd_pos_next[PAW-1:0]),
        .rdata (pq)
    );

    mqm_ram #(.WIDTH(8), .DEPTH(NTD)) u_name (
        .clk   (clk),
        .we    (name_we),
        .waddr (NTW'(NTW'(request.entry) * NTW'(NAME_BYTES) + NTW'(request.name_pos))),
        .wdata (request.data_byte),
        .raddr (NTW'(NTW'(e_next) * NTW'(NAME_BYTES) + NTW'(i_next))),
        .rdata (nq)
    );

    mqm_ram #(.WIDTH(8), .DEPTH(DOMAIN_BYTES)) u_dom (
        .clk   (clk),
        .we    (dom_we),
        .waddr (dom_used_reg[DAW-1:0]),
        .wdata (cmd.len_end ? 8'd0 : pq),
        .raddr (DAW'(i_next)),
        .rdata (dq)
    );

    mqm_ram #(.WIDTH(EW), .DEPTH(MAX_ANSWERS)) u_match (
        .clk   (clk),
        .we    (cmd.found),
        .waddr (mc_reg[MLW-1:0]),
        .wdata (e_reg[EW-1:0]),
        .raddr (k_next[MLW-1:0]),
        .rdata (mlq)
    );

    always_comb
    begin
        status.pkt_end      = request.func == mqm_pkg::FUNC_PACKET && request.end_of_packet;
        status.short_pkt    = plen_reg < PLW'(mqm_pkg::HDR_BYTES);
        status.hdr_last     = rd_pos_reg == RW'(mqm_pkg::HDR_BYTES - 1);
        status.hdr_ok       = (flags_reg & mqm_pkg::FLAG_MASK) == 8'd0 && qd_reg != 16'd0;
        status.q_done       = q_reg == qd_reg;
        status.none_matched = mc_reg == '0;
        status.byte_ok      = rd_pos_reg < RW'(plen_reg);
        status.dom_full     = dom_used_reg == DUW'(DOMAIN_BYTES);
        status.is_ptr       = (pq & mqm_pkg::PTR_MASK) == mqm_pkg::PTR_MASK;
        status.is_zero      = pq == 8'd0;
        status.depth_ok     = depth_reg < DPW'(MAX_POINTER_DEPTH);
        status.lab_last     = left_reg == 8'd1;
        status.tc_ok        = (type_reg == mqm_pkg::TYPE_A || type_reg == mqm_pkg::TYPE_ANY)
                              && (cls_m == mqm_pkg::CLASS_IN || cls_m == mqm_pkg::CLASS_ANY);
        status.ent_end      = e_reg == ECW'(NUM_RECORDS);
        status.ent_cand     = nlen != 8'd0 && 9'(nlen) <= 9'(NAME_BYTES)
                              && DUW'(nlen) == dom_used_reg;
        status.cmp_eq       = (cleft_reg != 8'd0) ? fold(nq) == fold(dq) : nq == dq;
        status.cmp_last     = 9'(i_reg) + 9'd1 == 9'(nlen);
        status.ml_full      = mc_reg >= MCW'(MAX_ANSWERS);
        status.emit_last    = k_reg + MCW'(1) == mc_reg;
    end

    assign answer_valid = ans_valid_reg;
    assign answer       = ans_reg;
endmodule

>>> dv/tb_mdns_query_matcher_unit.sv
// Self-checking testbench for mdns_query_matcher_unit: directed table plus random query packets.
// Depends on mqm_pkg and the RTL of the block; answers are checked against an in-bench predictor.
module tb_mdns_query_matcher_unit;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct {
        mqm_pkg::req_t r;
        bit            typed;
        mqm_pkg::ans_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    mqm_pkg::req_t request = '0;
    logic busy;
    logic answer_valid;
    mqm_pkg::ans_t answer;

    // predictor state
    logic [7:0]    pkt_mem[2048];
    int            pkt_len;
    logic [7:0]    host_name[16][256];
    logic [7:0]    host_len[16];
    logic [31:0]   host_ip[16];
    logic [7:0]    qname[512];
    int            qname_len;
    int            rd;
    bit            bad;
    mqm_pkg::ans_t pending[$];
    mqm_pkg::ans_t fresh[$];
    int            errors;

    // stimulus bookkeeping
    bit          written[16][256];
    bit          loaded[16];
    logic [7:0]  host_copy[16][$];
    logic [7:0]  nm_q[$];
    logic [7:0]  pk[$];
    int          name_offs[$];
    bit          burst;

    mdns_query_matcher_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .answer_valid(answer_valid),
        .answer(answer)
    );

    always #5 clk = ~clk;

    initial
    begin
        #50000000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [7:0] next_byte();
        if (rd < pkt_len)
        begin
            rd++;
            return pkt_mem[rd - 1];
        end
        bad = 1'b1;
        return 8'h00;
    endfunction

    function automatic logic [15:0] next_word();
        logic [15:0] w;
        w[15:8] = next_byte();
        w[7:0] = next_byte();
        return w;
    endfunction

    function automatic void push_qname(logic [7:0] b);
        if (qname_len < 512)
        begin
            qname[qname_len] = b;
            qname_len++;
        end
        else
            bad = 1'b1;
    endfunction

    function automatic void read_qname();
        int depth;
        int resume;
        int n;
        bit jumped;
        logic [7:0] len;
        logic [13:0] off;
        depth = 0;
        resume = 0;
        jumped = 1'b0;
        qname_len = 0;
        while (!bad)
        begin
            len = next_byte();
            if (bad)
                break;
            if ((len & mqm_pkg::PTR_MASK) == mqm_pkg::PTR_MASK)
            begin
                off[13:8] = len[5:0];
                off[7:0] = next_byte();
                if (bad)
                    break;
                if (depth < 8)
                begin
                    if (!jumped)
                    begin
                        jumped = 1'b1;
                        resume = rd;
                    end
                    rd = int'(off);
                    depth++;
                end
                else
                    bad = 1'b1;
            end
            else if (len != 0)
            begin
                push_qname(len);
                for (n = 0; n < len && !bad; n++)
                    push_qname(next_byte());
            end
            else
            begin
                push_qname(8'h00);
                break;
            end
        end
        if (jumped)
            rd = resume;
    endfunction

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic bit host_hit(int e);
        int left;
        int i;
        left = 0;
        if (host_len[e] == 0 || host_len[e] != qname_len)
            return 1'b0;
        for (i = 0; i < host_len[e]; i++)
        begin
            if (left > 0)
            begin
                if (fold_case(host_name[e][i]) != fold_case(qname[i]))
                    return 1'b0;
                left--;
            end
            else
            begin
                if (host_name[e][i] != qname[i])
                    return 1'b0;
                left = host_name[e][i];
            end
        end
        return 1'b1;
    endfunction

    function automatic void match_packet();
        logic [15:0] id;
        logic [15:0] flags;
        logic [15:0] qd;
        logic [15:0] qtype;
        logic [15:0] qclass;
        int q;
        int e;
        int hit;
        int k;
        logic [3:0] hits[$];
        mqm_pkg::ans_t a;
        fresh.delete();
        bad = 1'b0;
        if (pkt_len < mqm_pkg::HDR_BYTES)
            return;
        rd = 0;
        id = next_word();
        flags = next_word();
        qd = next_word();
        if ((flags[15:8] & mqm_pkg::FLAG_MASK) != 8'd0 || qd == 0)
            return;
        rd = mqm_pkg::HDR_BYTES;
        for (q = 0; q < qd; q++)
        begin
            read_qname();
            qtype = next_word();
            qclass = next_word();
            if (bad)
                return;
            if (qtype != mqm_pkg::TYPE_A && qtype != mqm_pkg::TYPE_ANY)
                continue;
            qclass = qclass & mqm_pkg::CLASS_MASK;
            if (qclass != mqm_pkg::CLASS_IN && qclass != mqm_pkg::CLASS_ANY)
                continue;
            hit = -1;
            for (e = 0; e < 16; e++)
            begin
                if (host_hit(e))
                begin
                    hit = e;
                    break;
                end
            end
            if (hit >= 0)
            begin
                if (hits.size() >= 32)
                    return;
                hits.push_back(4'(hit));
            end
        end
        for (k = 0; k < hits.size(); k++)
        begin
            a.query_id = id;
            a.answer_index = 5'(k);
            a.answer_count = 6'(hits.size());
            a.record_entry = hits[k];
            a.record_addr = host_ip[hits[k]];
            a.last_answer = (k + 1 == hits.size());
            fresh.push_back(a);
        end
    endfunction

    function automatic void predict_word(mqm_pkg::req_t r);
        fresh.delete();
        case (r.func)
            mqm_pkg::FUNC_PACKET:
            begin
                if (pkt_len < 2048)
                begin
                    pkt_mem[pkt_len] = r.data_byte;
                    pkt_len++;
                end
                if (r.end_of_packet)
                begin
                    match_packet();
                    pkt_len = 0;
                end
            end
            mqm_pkg::FUNC_NAME:
                host_name[r.entry][r.name_pos] = r.data_byte;
            mqm_pkg::FUNC_ENTRY:
            begin
                host_len[r.entry] = r.name_len;
                host_ip[r.entry] = r.host_addr;
            end
            default: ;
        endcase
    endfunction

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        mqm_pkg::ans_t exp_a;
        if (rst_n && answer_valid)
        begin
            if (pending.size() == 0)
                report("answer with none expected");
            else
            begin
                exp_a = pending.pop_front();
                if (answer.query_id !== exp_a.query_id)
                    report($sformatf("query_id %h exp %h", answer.query_id, exp_a.query_id));
                if (answer.answer_index !== exp_a.answer_index)
                    report($sformatf("answer_index %0d exp %0d",
                        answer.answer_index, exp_a.answer_index));
                if (answer.answer_count !== exp_a.answer_count)
                    report($sformatf("answer_count %0d exp %0d",
                        answer.answer_count, exp_a.answer_count));
                if (answer.record_entry !== exp_a.record_entry)
                    report($sformatf("record_entry %0d exp %0d",
                        answer.record_entry, exp_a.record_entry));
                if (answer.record_addr !== exp_a.record_addr)
                    report($sformatf("record_addr %h exp %h",
                        answer.record_addr, exp_a.record_addr));
                if (answer.last_answer !== exp_a.last_answer)
                    report($sformatf("last_answer %b exp %b",
                        answer.last_answer, exp_a.last_answer));
            end
        end
    end

    function automatic mqm_pkg::req_t mk(logic [1:0] f, logic [7:0] d, logic eop,
                                         logic [3:0] e, logic [7:0] p, logic [7:0] l,
                                         logic [31:0] a);
        mqm_pkg::req_t r;
        r.func = f;
        r.data_byte = d;
        r.end_of_packet = eop;
        r.entry = e;
        r.name_pos = p;
        r.name_len = l;
        r.host_addr = a;
        return r;
    endfunction

    function automatic mqm_pkg::req_t noise_req();
        return mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom());
    endfunction

    task automatic send_word(mqm_pkg::req_t r, bit typed, mqm_pkg::ans_t want);
        int gap;
        start <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        if (r.func == mqm_pkg::FUNC_NAME)
            written[r.entry][r.name_pos] = 1'b1;
        predict_word(r);
        if (typed)
            pending.push_back(want);
        else
            foreach (fresh[i])
                pending.push_back(fresh[i]);
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(mqm_pkg::req_t r);
        send_word(r, 1'b0, '0);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge clk);
        while ((pending.size() != 0 || busy) && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_packet();
        mqm_pkg::req_t r;
        burst = ($urandom_range(0, 2) == 0);
        foreach (pk[i])
        begin
            r = noise_req();
            r.func = mqm_pkg::FUNC_PACKET;
            r.data_byte = pk[i];
            r.end_of_packet = (i == pk.size() - 1);
            send(r);
        end
    endtask

    function automatic void make_name(int labels, int maxlen);
        int i;
        int j;
        int n;
        nm_q.delete();
        for (i = 0; i < labels; i++)
        begin
            n = $urandom_range(1, maxlen);
            nm_q.push_back(8'(n));
            for (j = 0; j < n; j++)
                case ($urandom_range(0, 5))
                    0: nm_q.push_back(8'($urandom_range(0, 255)));
                    1: nm_q.push_back(8'($urandom_range(8'h30, 8'h39)));
                    2, 3: nm_q.push_back(8'($urandom_range(8'h41, 8'h5a)));
                    default: nm_q.push_back(8'($urandom_range(8'h61, 8'h7a)));
                endcase
        end
        nm_q.push_back(8'h00);
    endfunction

    task automatic load_entry(int e);
        mqm_pkg::req_t r;
        foreach (nm_q[i])
        begin
            r = noise_req();
            r.func = mqm_pkg::FUNC_NAME;
            r.entry = 4'(e);
            r.name_pos = 8'(i);
            r.data_byte = nm_q[i];
            send(r);
        end
        r = noise_req();
        r.func = mqm_pkg::FUNC_ENTRY;
        r.entry = 4'(e);
        r.name_len = 8'(nm_q.size());
        send(r);
        host_copy[e] = nm_q;
        loaded[e] = 1'b1;
    endtask

    function automatic void add16(logic [15:0] w);
        pk.push_back(w[15:8]);
        pk.push_back(w[7:0]);
    endfunction

    function automatic void add_header(logic [15:0] flags, logic [15:0] qd);
        pk.delete();
        name_offs.delete();
        add16(16'($urandom_range(0, 16'hffff)));
        add16(flags);
        add16(qd);
        add16(16'($urandom_range(0, 16'hffff)));
        add16(16'($urandom_range(0, 16'hffff)));
        add16(16'($urandom_range(0, 16'hffff)));
    endfunction

    function automatic bit add_host_name();
        int e;
        logic [7:0] b;
        e = $urandom_range(0, 15);
        if (!loaded[e])
            return 1'b0;
        name_offs.push_back(pk.size());
        foreach (host_copy[e][i])
        begin
            b = host_copy[e][i];
            if (((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a))
                && $urandom_range(0, 1))
                b = b ^ 8'h20;
            pk.push_back(b);
        end
        return 1'b1;
    endfunction

    function automatic void add_question();
        int r;
        int off;
        r = $urandom_range(0, 9);
        if (r < 6 && add_host_name())
            ;
        else if (r < 8 && name_offs.size() > 0)
        begin
            off = name_offs[$urandom_range(0, name_offs.size() - 1)];
            if (r == 7)
            begin
                name_offs.push_back(pk.size());
                pk.push_back(8'd1);
                pk.push_back(8'($urandom_range(8'h61, 8'h7a)));
            end
            pk.push_back(mqm_pkg::PTR_MASK | {2'b00, off[13:8]});
            pk.push_back(off[7:0]);
        end
        else
        begin
            make_name($urandom_range(1, 3), 6);
            name_offs.push_back(pk.size());
            foreach (nm_q[i])
                pk.push_back(nm_q[i]);
        end
        case ($urandom_range(0, 5))
            0, 1: add16(mqm_pkg::TYPE_A);
            2, 3: add16(mqm_pkg::TYPE_ANY);
            4: add16(16'd28);
            default: add16(16'($urandom_range(0, 16'hffff)));
        endcase
        case ($urandom_range(0, 5))
            0, 1: add16(mqm_pkg::CLASS_IN | {1'($urandom_range(0, 1)), 15'd0});
            2, 3: add16(mqm_pkg::CLASS_ANY | {1'($urandom_range(0, 1)), 15'd0});
            4: add16(16'd3);
            default: add16(16'($urandom_range(0, 16'hffff)));
        endcase
    endfunction

    function automatic void well_formed(logic [15:0] flags);
        int qd;
        int i;
        qd = $urandom_range(1, 5);
        add_header(flags, 16'(qd));
        for (i = 0; i < qd; i++)
            add_question();
    endfunction

    // kinds: 0 normal, 1 truncated, 2 bad header, 3 noise, 4 pointer loop,
    // 5 pointer out of range, 6 long domain, 7 too many answers, 8 oversize
    function automatic void build_packet(int kind);
        int i;
        int n;
        case (kind)
            1:
            begin
                well_formed(16'($urandom_range(0, 11'h7ff)));
                n = $urandom_range(1, pk.size() - 1);
                repeat (n) void'(pk.pop_back());
            end
            2:
                if ($urandom_range(0, 1))
                    well_formed({5'($urandom_range(1, 31)), 11'($urandom())});
                else
                begin
                    well_formed(16'($urandom_range(0, 11'h7ff)));
                    pk[4] = 8'h00;
                    pk[5] = 8'h00;
                end
            3:
            begin
                pk.delete();
                n = $urandom_range(1, 40);
                repeat (n) pk.push_back(8'($urandom_range(0, 255)));
            end
            4, 5:
            begin
                add_header(16'h0000, 16'd1);
                if (kind == 4)
                begin
                    add16(16'hc00c);
                end
                else
                begin
                    pk.push_back(8'h01);
                    pk.push_back(8'h78);
                    add16(16'hffff);
                end
                add16(mqm_pkg::TYPE_A);
                add16(mqm_pkg::CLASS_IN);
            end
            6:
            begin
                add_header(16'h0000, 16'd1);
                repeat (9)
                begin
                    pk.push_back(8'd63);
                    repeat (63) pk.push_back(8'($urandom_range(0, 255)));
                end
                pk.push_back(8'h00);
                add16(mqm_pkg::TYPE_A);
                add16(mqm_pkg::CLASS_IN);
            end
            7:
            begin
                n = $urandom_range(32, 33);
                add_header(16'h0000, 16'(n));
                while (!add_host_name())
                    ;
                add16(mqm_pkg::TYPE_ANY);
                add16(mqm_pkg::CLASS_ANY);
                for (i = 1; i < n; i++)
                begin
                    add16(16'hc00c);
                    add16(mqm_pkg::TYPE_A);
                    add16(mqm_pkg::CLASS_IN);
                end
            end
            8:
            begin
                well_formed(16'h0000);
                while (pk.size() < 2100)
                    pk.push_back(8'($urandom_range(0, 255)));
            end
            default:
                well_formed(16'($urandom_range(0, 11'h7ff)));
        endcase
    endfunction

    initial
    begin
        dir_row_t rows[$];
        mqm_pkg::req_t r;
        int e;
        int p;
        int kind;
        int pkt;
        int guard;
        errors = 0;
        pkt_len = 0;
        foreach (host_len[i])
        begin
            host_len[i] = 8'h00;
            host_ip[i] = 32'h0;
        end
        // name "\x01a\x00" at entry 0, then an upper-case query for it
        rows = '{
            '{mk(mqm_pkg::FUNC_NAME,   8'h01, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_NAME,   8'h61, 1'b1, 4'h0, 8'h01, 8'hff, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_NAME,   8'h00, 1'b0, 4'h0, 8'h02, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_ENTRY,  8'hff, 1'b1, 4'h0, 8'hff, 8'h03, 32'hffffffff),
              1'b0, '0},
            '{mk(FUNC_NONE,            8'hff, 1'b1, 4'hf, 8'hff, 8'hff, 32'hffffffff),
              1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'hab, 1'b0, 4'hf, 8'hff, 8'hff, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'hcd, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h07, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'hff, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h01, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h01, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h41, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h00, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h01, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h80, 1'b0, 4'h0, 8'h00, 8'h00, 32'h0), 1'b0, '0},
            '{mk(mqm_pkg::FUNC_PACKET, 8'h01, 1'b1, 4'h0, 8'h00, 8'h00, 32'h0), 1'b1,
              '{16'habcd, 5'd0, 6'd1, 4'h0, 32'hffffffff, 1'b1}}
        };
        burst = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].r, rows[i].typed, rows[i].want);
        drain();

        // host table: short names, one duplicate, one unused, one full-size name
        for (e = 0; e < 15; e++)
        begin
            burst = ($urandom_range(0, 1) == 0);
            if (e == 5)
                nm_q = host_copy[2];
            else
                make_name($urandom_range(1, 3), 8);
            load_entry(e);
        end
        r = mk(mqm_pkg::FUNC_ENTRY, 8'h00, 1'b0, 4'd14, 8'h00, 8'h00, 32'h0);
        send(r);
        nm_q.delete();
        for (p = 0; p < 4; p++)
        begin
            nm_q.push_back(p == 3 ? 8'd61 : 8'd63);
            repeat (p == 3 ? 61 : 63) nm_q.push_back(8'($urandom_range(8'h41, 8'h7a)));
        end
        nm_q.push_back(8'h00);
        burst = 1'b1;
        load_entry(15);
        r = mk(mqm_pkg::FUNC_NAME, 8'hff, 1'b1, 4'd15, 8'hff, 8'h00, 32'h0);
        send(r);

        for (pkt = 0; pkt < 80; pkt++)
        begin
            if (pkt < 9)
                kind = pkt;
            else if (pkt % 20 == 19)
                kind = $urandom_range(6, 7);
            else
                kind = $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 5);
            build_packet(kind);
            send_packet();
            case ($urandom_range(0, 7))
                0: drain();
                1:
                begin
                    e = $urandom_range(0, 14);
                    make_name($urandom_range(1, 3), 8);
                    load_entry(e);
                end
                2:
                begin
                    burst = 1'b0;
                    r = noise_req();
                    if (r.func == mqm_pkg::FUNC_ENTRY)
                    begin
                        p = 0;
                        while (p < 255 && written[r.entry][p])
                            p++;
                        r.name_len = 8'($urandom_range(0, p));
                        loaded[r.entry] = 1'b0;
                    end
                    else if (r.func == mqm_pkg::FUNC_NAME)
                        loaded[r.entry] = 1'b0;
                    else if (r.func == mqm_pkg::FUNC_PACKET)
                        r.func = FUNC_NONE;
                    send(r);
                end
                default: ;
            endcase
        end

        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while ((pending.size() != 0 || busy) && guard < 500000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
